@@ design/amrp_pkg.sv @@
// ----------------------------------------------------------------------------
// amrp_pkg
// Shared types and constants of the manufacturer record parser: the command
// passed from the byte walker to the result builder, and fixed field widths.
// ----------------------------------------------------------------------------
package amrp_pkg;

    // fixed store and field sizes
    localparam int STORE_DEPTH  = 31;
    localparam int IDX_W        = 5;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int TDATA_W      = 80;

    // walk constants
    localparam logic [7:0] MFG_TYPE     = 8'hFF;
    localparam logic [7:0] MIN_MFG_LEN  = 8'd12;
    localparam logic [7:0] NEW_FORM_LEN = 8'd15;
    localparam logic [7:0] VERSION_ONE  = 8'd1;
    localparam logic [7:0] LAST_OFFSET  = 8'd255;
    localparam logic [8:0] MAX_START    = 9'd254;

    // relative offsets inside a manufacturer structure
    localparam logic [7:0] REL_TYPE     = 8'd1;
    localparam logic [7:0] REL_CID_LO   = 8'd2;
    localparam logic [7:0] REL_CID_HI   = 8'd3;
    localparam logic [7:0] REL_TAG1     = 8'd4;
    localparam logic [7:0] REL_TAG2     = 8'd5;
    localparam logic [7:0] REL_MAC0     = 8'd6;
    localparam logic [7:0] REL_MAC5     = 8'd11;
    localparam logic [7:0] REL_VERSION  = 8'd12;
    localparam logic [7:0] REL_CHANNEL  = 8'd13;
    localparam logic [7:0] REL_PTYPE    = 8'd14;
    localparam logic [7:0] REL_NAME_NEW = 8'd15;
    localparam logic [7:0] REL_NAME_OLD = 8'd12;

    // configuration register indexes
    localparam logic [7:0] CFG_COMPANY_ID  = 8'd0;
    localparam logic [7:0] CFG_TAG_FIRST   = 8'd1;
    localparam logic [7:0] CFG_TAG_SECOND  = 8'd2;
    localparam logic [7:0] CFG_LEGACY_TYPE = 8'd3;

    // configuration reset values
    localparam logic [15:0] RST_COMPANY_ID  = 16'h02E5;
    localparam logic [7:0]  RST_TAG_FIRST   = 8'h45;
    localparam logic [7:0]  RST_TAG_SECOND  = 8'h4E;
    localparam logic [7:0]  RST_LEGACY_TYPE = 8'h00;

    // action that one payload byte asks of the result builder
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MAC,
        OP_VER_NEW,
        OP_VER_LEG,
        OP_CHAN,
        OP_TYPE,
        OP_NAME
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic [7:0]       aux;
        logic             last;
        logic             found;
    } t_cmd;

    typedef enum logic {
        BK_RUN,
        BK_EMIT
    } t_back_state;

endpackage

@@ design/amrp_front.sv @@
// ----------------------------------------------------------------------------
// amrp_front
// Byte walker: accepts report bytes, tracks the length-type structures,
// matches the manufacturer record and issues one command per useful byte.
// ----------------------------------------------------------------------------
module amrp_front #(
    parameter int NAME_CAPACITY = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,
    input  logic              i_s_tlast,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output amrp_pkg::t_cmd    o_q_cmd
);

    localparam int NameLimitInt = (NAME_CAPACITY - 1 > amrp_pkg::STORE_DEPTH) ?
                                  amrp_pkg::STORE_DEPTH : NAME_CAPACITY - 1;
    localparam logic [7:0] NameLimit = 8'(NameLimitInt);

    // configuration registers
    logic [15:0] r_company_id;
    logic [7:0]  r_tag_first;
    logic [7:0]  r_tag_second;
    logic [7:0]  r_legacy_type;

    // walk state
    logic [7:0] r_offset, n_offset;
    logic [7:0] r_start, n_start;
    logic [7:0] r_len, n_len;
    logic       r_stopped, n_stopped;
    logic       r_cand, n_cand;
    logic       r_confirmed, n_confirmed;
    logic       r_ver_one, n_ver_one;

    logic           accept;
    logic           active;
    logic [7:0]     rel;
    logic [7:0]     name_idx;
    logic [8:0]     next_start;
    logic           new_form;
    amrp_pkg::t_cmd cmd;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && !i_q_full;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_company_id  <= amrp_pkg::RST_COMPANY_ID;
            r_tag_first   <= amrp_pkg::RST_TAG_FIRST;
            r_tag_second  <= amrp_pkg::RST_TAG_SECOND;
            r_legacy_type <= amrp_pkg::RST_LEGACY_TYPE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                amrp_pkg::CFG_COMPANY_ID:  r_company_id  <= i_cfg_data;
                amrp_pkg::CFG_TAG_FIRST:   r_tag_first   <= i_cfg_data[7:0];
                amrp_pkg::CFG_TAG_SECOND:  r_tag_second  <= i_cfg_data[7:0];
                amrp_pkg::CFG_LEGACY_TYPE: r_legacy_type <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign active = (r_offset != amrp_pkg::LAST_OFFSET) && !r_stopped && !r_confirmed
                    && (r_offset >= r_start);
    assign rel        = r_offset - r_start;
    assign next_start = {1'b0, r_start} + {1'b0, r_len} + 9'd1;
    assign new_form   = r_ver_one && (r_len >= amrp_pkg::NEW_FORM_LEN);
    assign name_idx   = new_form ? rel - amrp_pkg::REL_NAME_NEW : rel - amrp_pkg::REL_NAME_OLD;

    // classify the current byte and work out the next walk state
    always_comb begin
        n_offset    = r_offset;
        n_start     = r_start;
        n_len       = r_len;
        n_stopped   = r_stopped;
        n_cand      = r_cand;
        n_confirmed = r_confirmed;
        n_ver_one   = r_ver_one;
        cmd         = '0;
        cmd.op      = amrp_pkg::OP_NONE;
        cmd.data    = i_s_tdata;
        cmd.aux     = r_legacy_type;
        cmd.last    = i_s_tlast;

        if (r_offset != amrp_pkg::LAST_OFFSET) begin
            n_offset = r_offset + 8'd1;
        end

        if (active) begin
            if (rel == 8'd0) begin
                // length byte opens a structure, zero ends the walk
                if (i_s_tdata == 8'd0) begin
                    n_stopped = 1'b1;
                end else begin
                    n_len  = i_s_tdata;
                    n_cand = 1'b0;
                end
            end else begin
                if (rel == amrp_pkg::REL_TYPE) begin
                    n_cand = (i_s_tdata == amrp_pkg::MFG_TYPE)
                             && (r_len >= amrp_pkg::MIN_MFG_LEN);
                end else if (r_cand) begin
                    if (rel == amrp_pkg::REL_CID_LO) begin
                        n_cand = (i_s_tdata == r_company_id[7:0]);
                    end else if (rel == amrp_pkg::REL_CID_HI) begin
                        n_cand = (i_s_tdata == r_company_id[15:8]);
                    end else if (rel == amrp_pkg::REL_TAG1) begin
                        n_cand = (i_s_tdata == r_tag_first);
                    end else if (rel == amrp_pkg::REL_TAG2) begin
                        n_cand = (i_s_tdata == r_tag_second);
                    end else if (rel <= amrp_pkg::REL_MAC5) begin
                        cmd.op  = amrp_pkg::OP_MAC;
                        cmd.idx = 5'(rel - amrp_pkg::REL_MAC0);
                    end else if (rel == amrp_pkg::REL_VERSION) begin
                        n_ver_one = (i_s_tdata == amrp_pkg::VERSION_ONE);
                        if ((i_s_tdata == amrp_pkg::VERSION_ONE)
                            && (r_len >= amrp_pkg::NEW_FORM_LEN)) begin
                            cmd.op = amrp_pkg::OP_VER_NEW;
                        end else begin
                            // legacy form: version byte is the first name byte
                            cmd.op  = amrp_pkg::OP_VER_LEG;
                            cmd.idx = '0;
                        end
                    end else if ((rel == amrp_pkg::REL_CHANNEL) && new_form) begin
                        cmd.op = amrp_pkg::OP_CHAN;
                    end else if ((rel == amrp_pkg::REL_PTYPE) && new_form) begin
                        cmd.op = amrp_pkg::OP_TYPE;
                    end else if (name_idx < NameLimit) begin
                        cmd.op  = amrp_pkg::OP_NAME;
                        cmd.idx = name_idx[amrp_pkg::IDX_W-1:0];
                    end
                end

                // structure end: confirm the match or step to the next one
                if (rel == r_len) begin
                    if (n_cand) begin
                        n_confirmed = 1'b1;
                    end else if (next_start > amrp_pkg::MAX_START) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_start = next_start[7:0];
                    end
                end
            end
        end

        cmd.found = n_confirmed;
    end

    assign o_q_push = accept && ((cmd.op != amrp_pkg::OP_NONE) || i_s_tlast);
    assign o_q_cmd  = cmd;

    // walk state update, cleared at report end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_start     <= '0;
            r_len       <= '0;
            r_stopped   <= 1'b0;
            r_cand      <= 1'b0;
            r_confirmed <= 1'b0;
            r_ver_one   <= 1'b0;
        end else if (accept) begin
            if (i_s_tlast) begin
                r_offset    <= '0;
                r_start     <= '0;
                r_len       <= '0;
                r_stopped   <= 1'b0;
                r_cand      <= 1'b0;
                r_confirmed <= 1'b0;
                r_ver_one   <= 1'b0;
            end else begin
                r_offset    <= n_offset;
                r_start     <= n_start;
                r_len       <= n_len;
                r_stopped   <= n_stopped;
                r_cand      <= n_cand;
                r_confirmed <= n_confirmed;
                r_ver_one   <= n_ver_one;
            end
        end
    end

endmodule

@@ design/amrp_queue.sv @@
// ----------------------------------------------------------------------------
// amrp_queue
// Short command queue between the byte walker and the result builder.
// ----------------------------------------------------------------------------
module amrp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  amrp_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output amrp_pkg::t_cmd o_cmd
);

    amrp_pkg::t_cmd                r_mem [amrp_pkg::QUEUE_DEPTH];
    logic [amrp_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [amrp_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [amrp_pkg::QPTR_W:0]     r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == (amrp_pkg::QPTR_W + 1)'(amrp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/amrp_back.sv @@
// ----------------------------------------------------------------------------
// amrp_back
// Result builder: executes walker commands into the capture registers and
// the name store, then streams the header and name results of a report.
// ----------------------------------------------------------------------------
module amrp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  amrp_pkg::t_cmd                i_q_cmd,
    output logic                          o_q_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [amrp_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic                          o_m_tlast,
    output logic                          o_m_tuser
);

    amrp_pkg::t_back_state r_state, n_state;

    logic [47:0]              r_mac;
    logic [7:0]               r_channel;
    logic [7:0]               r_type;
    logic [7:0]               r_name [amrp_pkg::STORE_DEPTH];
    logic [amrp_pkg::IDX_W-1:0] r_count;
    logic                     r_found;
    logic [amrp_pkg::IDX_W-1:0] r_nlen;
    logic [amrp_pkg::IDX_W-1:0] r_k;

    logic                     r_out_valid;
    logic [amrp_pkg::TDATA_W-1:0] r_out_data;
    logic                     r_out_last;
    logic                     r_out_user;

    logic                     out_free;
    logic                     pop;
    logic                     emit;
    logic                     emit_done;
    logic [amrp_pkg::IDX_W-1:0] count_after;
    logic [amrp_pkg::IDX_W-1:0] name_addr;
    logic [7:0]               name_byte;
    logic [47:0]              mac_out;
    logic [7:0]               ch_out;
    logic [7:0]               ty_out;

    assign out_free  = !r_out_valid || i_m_tready;
    assign emit_done = emit && (r_k == r_nlen);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            amrp_pkg::BK_RUN: begin
                if (!i_q_empty && i_q_cmd.last) begin
                    n_state = amrp_pkg::BK_EMIT;
                end
            end
            amrp_pkg::BK_EMIT: begin
                if (out_free && (r_k == r_nlen)) begin
                    n_state = amrp_pkg::BK_RUN;
                end
            end
            default: n_state = amrp_pkg::BK_RUN;
        endcase
    end

    // state outputs
    always_comb begin
        pop  = 1'b0;
        emit = 1'b0;
        case (r_state)
            amrp_pkg::BK_RUN:  pop  = !i_q_empty;
            amrp_pkg::BK_EMIT: emit = out_free;
            default: ;
        endcase
    end

    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= amrp_pkg::BK_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // name count after the popped command
    always_comb begin
        count_after = r_count;
        if ((i_q_cmd.op == amrp_pkg::OP_NAME) || (i_q_cmd.op == amrp_pkg::OP_VER_LEG)) begin
            count_after = i_q_cmd.idx + 1'b1;
        end
    end

    // name store writes
    always_ff @(posedge i_clk) begin
        if (pop && ((i_q_cmd.op == amrp_pkg::OP_NAME)
                    || (i_q_cmd.op == amrp_pkg::OP_VER_LEG))) begin
            r_name[i_q_cmd.idx] <= i_q_cmd.data;
        end
    end

    // capture registers and readout counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac     <= '0;
            r_channel <= '0;
            r_type    <= '0;
            r_count   <= '0;
            r_found   <= 1'b0;
            r_nlen    <= '0;
            r_k       <= '0;
        end else if (pop) begin
            case (i_q_cmd.op)
                amrp_pkg::OP_MAC:     r_mac[i_q_cmd.idx[2:0]*8 +: 8] <= i_q_cmd.data;
                amrp_pkg::OP_VER_NEW: begin
                    r_channel <= '0;
                    r_type    <= '0;
                end
                amrp_pkg::OP_VER_LEG: begin
                    r_channel <= '0;
                    r_type    <= i_q_cmd.aux;
                end
                amrp_pkg::OP_CHAN:    r_channel <= i_q_cmd.data;
                amrp_pkg::OP_TYPE:    r_type    <= i_q_cmd.data;
                default: ;
            endcase
            r_count <= count_after;
            if (i_q_cmd.last) begin
                r_found <= i_q_cmd.found;
                r_nlen  <= i_q_cmd.found ? count_after : '0;
                r_k     <= '0;
            end
        end else if (emit) begin
            if (emit_done) begin
                // report finished: clear per-report captures
                r_mac     <= '0;
                r_channel <= '0;
                r_type    <= '0;
                r_count   <= '0;
                r_found   <= 1'b0;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // result fields
    assign name_addr = r_k - 1'b1;
    assign name_byte = (r_k == '0) ? 8'd0 : r_name[name_addr];
    assign mac_out   = r_found ? r_mac : '0;
    assign ch_out    = r_found ? r_channel : '0;
    assign ty_out    = r_found ? r_type : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= {2'b00, name_byte, r_nlen, ty_out, ch_out, mac_out, r_found};
            r_out_last <= (r_k == r_nlen);
            r_out_user <= (r_k != '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

endmodule

@@ design/adv_mfg_record_parser_top.sv @@
// ----------------------------------------------------------------------------
// adv_mfg_record_parser_top
// Parses one advertising report per frame and reports the first matching
// manufacturer record: header result followed by one result per name byte.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one payload byte per transaction, tlast on the final
//   byte of a report. Master stream gives a header transaction (tuser 0)
//   and then one transaction per name byte (tuser 1); tlast marks the final
//   result of the report. The config channel writes company id, two tag
//   bytes and the legacy peer type by index, and is always ready.
//   Throughput: one byte per cycle on input while the four-entry command
//   queue has room. Once the final byte's command is popped, the builder
//   registers the header; name results then follow one per cycle while the
//   receiver is ready. Meanwhile the next report's commands fill the queue,
//   and input stalls once it is full.
//   Reset clears all walk state and loads the default config values.
//   A stalled receiver holds the output register; the builder waits and the
//   queue backs up to the input.
// ----------------------------------------------------------------------------
module adv_mfg_record_parser_top #(
    parameter int NAME_CAPACITY = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // data_byte
    input  logic [7:0]                    i_s_tdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic                          i_s_tlast,
    // found[0], peer_mac[48:1], channel[56:49], node_type[64:57],
    // name_size[69:65], name_byte[77:70], zero[79:78]
    output logic [amrp_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic                          o_m_tlast,
    // is_name
    output logic                          o_m_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [7:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    amrp_pkg::t_cmd q_in;
    amrp_pkg::t_cmd q_out;

    assign o_cfg_ready = 1'b1;

    // byte walker
    amrp_front #(
        .NAME_CAPACITY(NAME_CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in)
    );

    // command queue
    amrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out)
    );

    // result builder
    amrp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_out),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
